// ===== src/track_shape_from_runs_defines.svh =====
// Assertion macros for the track shape estimator.
// Used by the checker module; expects signals clk and rst_n in the calling scope.
`ifndef TRACK_SHAPE_FROM_RUNS_DEFINES_SVH
`define TRACK_SHAPE_FROM_RUNS_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define TSR_ASSERT_IMP(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define TSR_ASSERT_NXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== src/tsr_pkg.sv =====
// Shared types, constants and helper functions of the track shape estimator.
// No dependencies; every other file but the assertion macro header imports this package.
package tsr_pkg;

    localparam int DEF_MAX_COLS = 2048;
    localparam int DEF_MAX_ROWS = 1024;
    localparam int QUEUE_DEPTH  = 4;

    localparam int PIXEL_W      = 8;
    localparam int ROW_WIDTH_W  = 12;
    localparam int FRAME_ROWS_W = 11;
    localparam int OUT_W        = 11;
    localparam int CFG_INDEX_W  = 3;
    localparam int CFG_DATA_W   = 12;

    localparam logic [ROW_WIDTH_W-1:0]  RST_ROW_WIDTH  = 12'd640;
    localparam logic [FRAME_ROWS_W-1:0] RST_FRAME_ROWS = 11'd480;
    localparam logic [PIXEL_W-1:0]      RST_LEVEL_LOW  = 8'd0;
    localparam logic [PIXEL_W-1:0]      RST_LEVEL_MID  = 8'd128;
    localparam logic [PIXEL_W-1:0]      RST_LEVEL_HIGH = 8'd255;

    typedef enum logic [CFG_INDEX_W-1:0] {
        REG_ROW_WIDTH,
        REG_FRAME_ROWS,
        REG_LEVEL_LOW,
        REG_LEVEL_MID,
        REG_LEVEL_HIGH
    } reg_index_t;

    typedef enum logic [1:0] {
        CLS_OTHER,
        CLS_LOW,
        CLS_MID,
        CLS_HIGH
    } class_t;

    typedef enum logic [1:0] {
        VERD_NONE,
        VERD_RIGHT,
        VERD_LEFT,
        VERD_STRAIGHT
    } verdict_t;

    typedef struct packed {
        logic [PIXEL_W-1:0] low;
        logic [PIXEL_W-1:0] mid;
        logic [PIXEL_W-1:0] high;
    } levels_t;

    // One request from the front end: an optional run closed by a change of value,
    // and an optional last run of the row, which also marks the row end.
    typedef struct packed {
        logic   has_a;
        class_t type_a;
        logic   row_end;
        class_t type_b;
        logic   frame_end;
    } ev_flags_t;

    // When several levels are equal, the later one in low, mid, high wins.
    function automatic class_t classify(input logic [PIXEL_W-1:0] v, input levels_t lv);
        class_t c;
        if (v == lv.high)
            c = CLS_HIGH;
        else if (v == lv.mid)
            c = CLS_MID;
        else if (v == lv.low)
            c = CLS_LOW;
        else
            c = CLS_OTHER;
        return c;
    endfunction

endpackage

// ===== src/tsr_ifs.sv =====
// Handshake channels of the track shape estimator: pixels in, verdicts out, register writes.
// Depends on tsr_pkg for field widths and the verdict type.
interface tsr_pixel_if;
    import tsr_pkg::*;
    logic               valid;
    logic               ready;
    logic [PIXEL_W-1:0] pixel;
    modport source (output valid, output pixel, input ready);
    modport sink (input valid, input pixel, output ready);
endinterface

interface tsr_result_if;
    import tsr_pkg::*;
    logic             valid;
    logic             ready;
    verdict_t         verdict;
    logic [OUT_W-1:0] rows_matched;
    logic [OUT_W-1:0] first_center;
    logic [OUT_W-1:0] last_center;
    modport source (output valid, output verdict, output rows_matched,
                    output first_center, output last_center, input ready);
    modport sink (input valid, input verdict, input rows_matched,
                  input first_center, input last_center, output ready);
endinterface

interface tsr_cfg_if;
    import tsr_pkg::*;
    logic                   valid;
    logic                   ready;
    logic [CFG_INDEX_W-1:0] index;
    logic [CFG_DATA_W-1:0]  wdata;
    modport source (output valid, output index, output wdata, input ready);
    modport sink (input valid, input index, input wdata, output ready);
endinterface

// ===== src/tsr_front.sv =====
// Front end: run-length codes each row and turns closed runs into requests for the queue.
// Depends on tsr_pkg for the classifier and the request flag type.
module tsr_front #(
    parameter int MAX_COLS = tsr_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tsr_pkg::DEF_MAX_ROWS,
    localparam int CW  = $clog2(MAX_COLS),
    localparam int LW  = $clog2(MAX_COLS + 1),
    localparam int RCW = $clog2(MAX_ROWS + 1)
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     pix_valid,
    output logic                     pix_ready,
    input  logic [7:0]               pix,
    input  tsr_pkg::levels_t         levels,
    input  logic [LW-1:0]            cols,
    input  logic [RCW-1:0]           rows,
    output logic                     ev_valid,
    input  logic                     ev_ready,
    output tsr_pkg::ev_flags_t       ev_flags,
    output logic [CW-1:0]            ev_mid_a,
    output logic [CW-1:0]            ev_mid_b
);
    import tsr_pkg::*;

    logic [CW-1:0]      col_reg, col_next;
    logic [RCW-1:0]     row_reg, row_next;
    logic [PIXEL_W-1:0] run_val_reg, run_val_next;
    logic [LW-1:0]      run_len_reg, run_len_next;
    logic               accept;
    logic               first_px;
    logic               close_a;
    logic               row_end;
    logic               frame_end;

    // Midpoint of a run: its last column minus half its length, rounded down.
    function automatic logic [CW-1:0] midpoint(input logic [CW-1:0] last_idx,
                                               input logic [LW-1:0] len);
        logic [LW-1:0] half;
        logic [LW-1:0] last_ext;
        logic [LW-1:0] diff;
        half     = len >> 1;
        last_ext = LW'(last_idx);
        diff     = (last_ext >= half) ? last_ext - half : '0;
        return CW'(diff);
    endfunction

    assign pix_ready = ev_ready;
    assign accept    = pix_valid && pix_ready;

    always_comb
    begin
        first_px = (col_reg == '0);
        close_a  = !first_px && (pix != run_val_reg);

        if (first_px || close_a)
        begin
            run_val_next = pix;
            run_len_next = LW'(1);
        end
        else
        begin
            run_val_next = run_val_reg;
            run_len_next = run_len_reg + LW'(1);
        end

        row_end   = (LW'(col_reg) + LW'(1)) >= cols;
        frame_end = row_end && ((row_reg + RCW'(1)) >= rows);

        col_next = row_end ? '0 : col_reg + CW'(1);
        if (frame_end)
            row_next = '0;
        else if (row_end)
            row_next = row_reg + RCW'(1);
        else
            row_next = row_reg;

        ev_valid           = pix_valid && (close_a || row_end);
        ev_flags.has_a     = close_a;
        ev_flags.type_a    = classify(run_val_reg, levels);
        ev_flags.row_end   = row_end;
        ev_flags.type_b    = classify(run_val_next, levels);
        ev_flags.frame_end = frame_end;
        ev_mid_a           = midpoint(col_reg - CW'(1), run_len_reg);
        ev_mid_b           = midpoint(col_reg, run_len_next);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg     <= '0;
            row_reg     <= '0;
            run_val_reg <= '0;
            run_len_reg <= '0;
        end
        else if (accept)
        begin
            col_reg     <= col_next;
            row_reg     <= row_next;
            run_val_reg <= run_val_next;
            run_len_reg <= run_len_next;
        end
    end

endmodule

// ===== src/tsr_queue.sv =====
// Short first-in first-out queue that decouples the front end from the back end.
// Depends on tsr_pkg for its default depth.
module tsr_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = tsr_pkg::QUEUE_DEPTH,
    localparam int PW  = $clog2(DEPTH),
    localparam int CNW = $clog2(DEPTH + 1)
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push_valid,
    output logic             push_ready,
    input  logic [WIDTH-1:0] push_data,
    output logic             pop_valid,
    input  logic             pop_ready,
    output logic [WIDTH-1:0] pop_data
);
    import tsr_pkg::*;

    logic [WIDTH-1:0] slot_reg [DEPTH];
    logic [PW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CNW-1:0]   count_reg, count_next;
    logic             push;
    logic             pop;

    assign push_ready = (count_reg != CNW'(DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_data   = slot_reg[rd_ptr_reg];
    assign push       = push_valid && push_ready;
    assign pop        = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (push)
            wr_ptr_next = (wr_ptr_reg == PW'(DEPTH - 1)) ? '0 : wr_ptr_reg + PW'(1);
        if (pop)
            rd_ptr_next = (rd_ptr_reg == PW'(DEPTH - 1)) ? '0 : rd_ptr_reg + PW'(1);
        count_next = count_reg + CNW'(push) - CNW'(pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
            slot_reg[wr_ptr_reg] <= push_data;
    end

endmodule

// ===== src/tsr_back.sv =====
// Back end: looks for the 1,3,2,3,1 class pattern in each row and gathers frame statistics.
// Depends on tsr_pkg for the class codes and the request flag type.
module tsr_back #(
    parameter int MAX_COLS = tsr_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tsr_pkg::DEF_MAX_ROWS,
    localparam int CW  = $clog2(MAX_COLS),
    localparam int RCW = $clog2(MAX_ROWS + 1)
) (
    input  logic               clk,
    input  logic               rst_n,
    input  logic               ev_valid,
    output logic               ev_ready,
    input  tsr_pkg::ev_flags_t ev_flags,
    input  logic [CW-1:0]      ev_mid_a,
    input  logic [CW-1:0]      ev_mid_b,
    output logic               sum_valid,
    input  logic               sum_ready,
    output logic [RCW-1:0]     sum_match,
    output logic [CW-1:0]      sum_first,
    output logic [CW-1:0]      sum_last
);
    import tsr_pkg::*;

    // Per-row matcher state; types[0] is the oldest of the last four runs.
    typedef struct packed {
        class_t [3:0]          types;
        logic   [1:0][CW-1:0]  mids;
        logic   [2:0]          count;
        logic                  matched;
        logic   [CW-1:0]       center;
    } row_state_t;

    row_state_t     row_reg, row_next, row_work;
    logic [RCW-1:0] match_reg, match_next;
    logic [CW-1:0]  first_reg, first_next;
    logic [CW-1:0]  last_reg, last_next;
    logic           any_reg, any_next;
    logic           sum_valid_reg, sum_valid_next;
    logic [RCW-1:0] sum_match_reg;
    logic [CW-1:0]  sum_first_reg, sum_last_reg;
    logic           sum_free;
    logic           pop;

    function automatic row_state_t close_run(input row_state_t s, input class_t t,
                                             input logic [CW-1:0] mid);
        row_state_t r;
        r = s;
        if (!s.matched && s.count >= 3'd4 && s.types[0] == CLS_LOW &&
            s.types[1] == CLS_HIGH && s.types[2] == CLS_MID &&
            s.types[3] == CLS_HIGH && t == CLS_LOW)
        begin
            r.matched = 1'b1;
            r.center  = s.mids[0];
        end
        r.types[0] = s.types[1];
        r.types[1] = s.types[2];
        r.types[2] = s.types[3];
        r.types[3] = t;
        r.mids[0]  = s.mids[1];
        r.mids[1]  = mid;
        if (s.count < 3'd4)
            r.count = s.count + 3'd1;
        return r;
    endfunction

    assign sum_free  = !sum_valid_reg || sum_ready;
    assign ev_ready  = !ev_flags.frame_end || sum_free;
    assign pop       = ev_valid && ev_ready;
    assign sum_valid = sum_valid_reg;
    assign sum_match = sum_match_reg;
    assign sum_first = sum_first_reg;
    assign sum_last  = sum_last_reg;

    always_comb
    begin
        row_work = row_reg;
        if (ev_flags.has_a)
            row_work = close_run(row_work, ev_flags.type_a, ev_mid_a);
        if (ev_flags.row_end)
            row_work = close_run(row_work, ev_flags.type_b, ev_mid_b);

        row_next   = row_work;
        match_next = match_reg;
        first_next = first_reg;
        last_next  = last_reg;
        any_next   = any_reg;
        if (ev_flags.row_end)
        begin
            row_next = '0;
            if (row_work.matched)
            begin
                match_next = match_reg + RCW'(1);
                if (!any_reg)
                    first_next = row_work.center;
                last_next = row_work.center;
                any_next  = 1'b1;
            end
        end

        if (pop && ev_flags.frame_end)
            sum_valid_next = 1'b1;
        else if (sum_ready)
            sum_valid_next = 1'b0;
        else
            sum_valid_next = sum_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_reg       <= '0;
            match_reg     <= '0;
            first_reg     <= '0;
            last_reg      <= '0;
            any_reg       <= 1'b0;
            sum_valid_reg <= 1'b0;
        end
        else
        begin
            sum_valid_reg <= sum_valid_next;
            if (pop)
            begin
                row_reg <= row_next;
                if (ev_flags.frame_end)
                begin
                    match_reg <= '0;
                    first_reg <= '0;
                    last_reg  <= '0;
                    any_reg   <= 1'b0;
                end
                else
                begin
                    match_reg <= match_next;
                    first_reg <= first_next;
                    last_reg  <= last_next;
                    any_reg   <= any_next;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && ev_flags.frame_end)
        begin
            sum_match_reg <= match_next;
            sum_first_reg <= first_next;
            sum_last_reg  <= last_next;
        end
    end

endmodule

// ===== src/tsr_verdict.sv =====
// Verdict stage: turns a frame summary into the result and holds it in the output register.
// Depends on tsr_pkg for the verdict codes and the result field width.
module tsr_verdict #(
    parameter int MAX_COLS = tsr_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tsr_pkg::DEF_MAX_ROWS,
    localparam int CW  = $clog2(MAX_COLS),
    localparam int LW  = $clog2(MAX_COLS + 1),
    localparam int RCW = $clog2(MAX_ROWS + 1)
) (
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      sum_valid,
    output logic                      sum_ready,
    input  logic [RCW-1:0]            sum_match,
    input  logic [CW-1:0]             sum_first,
    input  logic [CW-1:0]             sum_last,
    input  logic [LW-1:0]             cols,
    input  logic [RCW-1:0]            rows,
    output logic                      res_valid,
    input  logic                      res_ready,
    output tsr_pkg::verdict_t         verdict,
    output logic [tsr_pkg::OUT_W-1:0] rows_matched,
    output logic [tsr_pkg::OUT_W-1:0] first_center,
    output logic [tsr_pkg::OUT_W-1:0] last_center
);
    import tsr_pkg::*;

    localparam int MW = RCW + 4;
    localparam int DW = CW + 4;

    logic [MW-1:0]    match_x10;
    logic [MW-1:0]    rows_x7;
    logic [CW-1:0]    drift;
    logic [DW-1:0]    dist_x10;
    logic             going_back;
    verdict_t         verdict_next;
    logic             load;
    logic             res_valid_reg;
    verdict_t         verdict_reg;
    logic [OUT_W-1:0] rows_matched_reg;
    logic [OUT_W-1:0] first_center_reg;
    logic [OUT_W-1:0] last_center_reg;

    assign sum_ready = !res_valid_reg || res_ready;
    assign load      = sum_valid && sum_ready;

    // Coverage test (matched*10 < rows*7) and drift test (|last-first|*10 against cols).
    always_comb
    begin
        match_x10  = MW'(sum_match) * MW'(10);
        rows_x7    = MW'(rows) * MW'(7);
        going_back = sum_last < sum_first;
        drift      = going_back ? sum_first - sum_last : sum_last - sum_first;
        dist_x10   = DW'(drift) * DW'(10);
        if (match_x10 < rows_x7)
            verdict_next = VERD_NONE;
        else if (dist_x10 > DW'(cols))
            verdict_next = going_back ? VERD_RIGHT : VERD_LEFT;
        else
            verdict_next = VERD_STRAIGHT;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            res_valid_reg <= 1'b0;
        else if (load)
            res_valid_reg <= 1'b1;
        else if (res_ready)
            res_valid_reg <= 1'b0;
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            verdict_reg      <= verdict_next;
            rows_matched_reg <= OUT_W'(sum_match);
            first_center_reg <= OUT_W'(sum_first);
            last_center_reg  <= OUT_W'(sum_last);
        end
    end

    assign res_valid    = res_valid_reg;
    assign verdict      = verdict_reg;
    assign rows_matched = rows_matched_reg;
    assign first_center = first_center_reg;
    assign last_center  = last_center_reg;

endmodule

// ===== src/track_shape_from_runs.sv =====
// Top level of the track shape estimator: register file, front end, queue, back end, verdict.
// Depends on tsr_pkg, the channel interfaces and the four submodules.

// Takes one grey pixel per clock in raster order while pixels are not held off: the front
// end codes runs and classifies them in the cycle a pixel arrives, and the back end takes
// one queued request per cycle unless a frame end waits on the summary register. A frame's
// result goes through the queue, summary register and output register after its last
// pixel is accepted. Pixels are held off only while a verdict waits on the output, a second
// frame summary waits behind it, and a third frame end has backed up the four-entry request
// queue. A width or row count of zero is taken as one; values above MAX_COLS or MAX_ROWS
// are clipped to those limits. Register writes are always accepted and take effect at once;
// a column counter already past a new width ends its row on the next pixel.
module track_shape_from_runs #(
    parameter int MAX_COLS = tsr_pkg::DEF_MAX_COLS,
    parameter int MAX_ROWS = tsr_pkg::DEF_MAX_ROWS
) (
    input  logic         clk,
    input  logic         rst_n,
    tsr_pixel_if.sink    pixels,
    tsr_result_if.source results,
    tsr_cfg_if.sink      cfg
);
    import tsr_pkg::*;

    localparam int CW  = $clog2(MAX_COLS);
    localparam int LW  = $clog2(MAX_COLS + 1);
    localparam int RCW = $clog2(MAX_ROWS + 1);
    localparam int QW  = $bits(ev_flags_t) + 2 * CW;

    logic [ROW_WIDTH_W-1:0]  row_width_reg;
    logic [FRAME_ROWS_W-1:0] frame_rows_reg;
    levels_t                 levels_reg;
    logic [31:0]             cols_wide;
    logic [31:0]             rows_wide;
    logic [LW-1:0]           cols;
    logic [RCW-1:0]          rows;

    logic                    fe_valid, fe_ready;
    ev_flags_t               fe_flags;
    logic [CW-1:0]           fe_mid_a, fe_mid_b;
    logic                    be_valid, be_ready;
    ev_flags_t               be_flags;
    logic [CW-1:0]           be_mid_a, be_mid_b;
    logic [QW-1:0]           q_in, q_out;

    logic                    sum_valid, sum_ready;
    logic [RCW-1:0]          sum_match;
    logic [CW-1:0]           sum_first, sum_last;

    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            row_width_reg   <= RST_ROW_WIDTH;
            frame_rows_reg  <= RST_FRAME_ROWS;
            levels_reg.low  <= RST_LEVEL_LOW;
            levels_reg.mid  <= RST_LEVEL_MID;
            levels_reg.high <= RST_LEVEL_HIGH;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (reg_index_t'(cfg.index))
                REG_ROW_WIDTH:  row_width_reg   <= cfg.wdata;
                REG_FRAME_ROWS: frame_rows_reg  <= cfg.wdata[FRAME_ROWS_W-1:0];
                REG_LEVEL_LOW:  levels_reg.low  <= cfg.wdata[PIXEL_W-1:0];
                REG_LEVEL_MID:  levels_reg.mid  <= cfg.wdata[PIXEL_W-1:0];
                REG_LEVEL_HIGH: levels_reg.high <= cfg.wdata[PIXEL_W-1:0];
                default:        ;
            endcase
        end
    end

    // Effective frame geometry: zero counts as one, oversize values are clipped.
    always_comb
    begin
        cols_wide = 32'(row_width_reg);
        if (cols_wide == 32'd0)
            cols_wide = 32'd1;
        if (cols_wide > 32'(MAX_COLS))
            cols_wide = 32'(MAX_COLS);
        rows_wide = 32'(frame_rows_reg);
        if (rows_wide == 32'd0)
            rows_wide = 32'd1;
        if (rows_wide > 32'(MAX_ROWS))
            rows_wide = 32'(MAX_ROWS);
        cols = LW'(cols_wide);
        rows = RCW'(rows_wide);
    end

    tsr_front #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_front (
        .clk       (clk),
        .rst_n     (rst_n),
        .pix_valid (pixels.valid),
        .pix_ready (pixels.ready),
        .pix       (pixels.pixel),
        .levels    (levels_reg),
        .cols      (cols),
        .rows      (rows),
        .ev_valid  (fe_valid),
        .ev_ready  (fe_ready),
        .ev_flags  (fe_flags),
        .ev_mid_a  (fe_mid_a),
        .ev_mid_b  (fe_mid_b)
    );

    assign q_in = {fe_flags, fe_mid_a, fe_mid_b};
    assign {be_flags, be_mid_a, be_mid_b} = q_out;

    tsr_queue #(
        .WIDTH (QW),
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (fe_valid),
        .push_ready (fe_ready),
        .push_data  (q_in),
        .pop_valid  (be_valid),
        .pop_ready  (be_ready),
        .pop_data   (q_out)
    );

    tsr_back #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .ev_valid  (be_valid),
        .ev_ready  (be_ready),
        .ev_flags  (be_flags),
        .ev_mid_a  (be_mid_a),
        .ev_mid_b  (be_mid_b),
        .sum_valid (sum_valid),
        .sum_ready (sum_ready),
        .sum_match (sum_match),
        .sum_first (sum_first),
        .sum_last  (sum_last)
    );

    tsr_verdict #(
        .MAX_COLS (MAX_COLS),
        .MAX_ROWS (MAX_ROWS)
    ) u_verdict (
        .clk          (clk),
        .rst_n        (rst_n),
        .sum_valid    (sum_valid),
        .sum_ready    (sum_ready),
        .sum_match    (sum_match),
        .sum_first    (sum_first),
        .sum_last     (sum_last),
        .cols         (cols),
        .rows         (rows),
        .res_valid    (results.valid),
        .res_ready    (results.ready),
        .verdict      (results.verdict),
        .rows_matched (results.rows_matched),
        .first_center (results.first_center),
        .last_center  (results.last_center)
    );

endmodule

// ===== src/tsr_checker.sv =====
// Port-level checker for the track shape estimator, bound to the top level.
// Depends on tsr_pkg and the assertion macros in track_shape_from_runs_defines.svh.
`include "track_shape_from_runs_defines.svh"

module tsr_checker (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      res_valid,
    input logic                      res_ready,
    input logic [1:0]                verdict,
    input logic [tsr_pkg::OUT_W-1:0] rows_matched,
    input logic [tsr_pkg::OUT_W-1:0] first_center,
    input logic [tsr_pkg::OUT_W-1:0] last_center
);
    import tsr_pkg::*;

    // A stalled request must stay offered.
    `TSR_ASSERT_NXT(a_res_hold, res_valid && !res_ready, res_valid, "result dropped while stalled")

    // A stalled request must not change its payload.
    `TSR_ASSERT_NXT(a_res_stable, res_valid && !res_ready, $stable(verdict) && $stable(rows_matched) && $stable(first_center) && $stable(last_center), "result changed while stalled")

    // Any estimate needs at least one matched row.
    `TSR_ASSERT_IMP(a_estimate_needs_rows, res_valid && verdict != VERD_NONE, rows_matched != '0, "estimate reported with no matched rows")

    // With no matched row the centres must still read as cleared.
    `TSR_ASSERT_IMP(a_no_rows_no_centres, res_valid && rows_matched == '0, first_center == '0 && last_center == '0, "centres set without a matched row")

endmodule

bind track_shape_from_runs tsr_checker u_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .res_valid    (results.valid),
    .res_ready    (results.ready),
    .verdict      (results.verdict),
    .rows_matched (results.rows_matched),
    .first_center (results.first_center),
    .last_center  (results.last_center)
);

// ===== bench/testbench.sv =====
// Self-checking bench for the run-based track shape estimator: drives pixel frames and
// register writes, predicts each frame verdict and checks every verdict request.
// Depends on tsr_pkg, the channel interfaces in tsr_ifs.sv and track_shape_from_runs.
module testbench;
    import tsr_pkg::*;

    localparam int ITEM_TARGET   = 1400;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 10;
    localparam int QUIET_LIMIT   = 2000;

    typedef struct packed {
        verdict_t         verdict;
        logic [OUT_W-1:0] rows_matched;
        logic [OUT_W-1:0] first_center;
        logic [OUT_W-1:0] last_center;
    } verdict_rec_t;

    // Predicts the frame verdicts from the accepted pixels and holds them until they arrive.
    class verdict_board;
        logic [ROW_WIDTH_W-1:0]  row_width;
        logic [FRAME_ROWS_W-1:0] frame_rows;
        logic [PIXEL_W-1:0]      lvl_low;
        logic [PIXEL_W-1:0]      lvl_mid;
        logic [PIXEL_W-1:0]      lvl_high;

        logic [11:0]        col_pos;
        logic [11:0]        row_pos;
        logic [PIXEL_W-1:0] run_val;
        logic [11:0]        run_len;
        class_t             run_cls [4];
        logic [OUT_W-1:0]   run_mid [2];
        int                 runs_seen;
        bit                 row_hit;
        logic [OUT_W-1:0]   row_mid;
        logic [OUT_W-1:0]   hits;
        logic [OUT_W-1:0]   first_mid;
        logic [OUT_W-1:0]   last_mid;
        bit                 any_hit;

        verdict_rec_t pending_verdicts [$];
        int unsigned  errors;
        int unsigned  checked;
        int unsigned  verdict_tally [4];

        function new();
            row_width  = RST_ROW_WIDTH;
            frame_rows = RST_FRAME_ROWS;
            lvl_low    = RST_LEVEL_LOW;
            lvl_mid    = RST_LEVEL_MID;
            lvl_high   = RST_LEVEL_HIGH;
            clear_row();
            row_pos   = '0;
            hits      = '0;
            first_mid = '0;
            last_mid  = '0;
            any_hit   = 1'b0;
            errors    = 0;
            checked   = 0;
            foreach (verdict_tally[i]) verdict_tally[i] = 0;
        endfunction

        function int eff_cols();
            int c;
            c = row_width;
            if (c == 0) c = 1;
            if (c > DEF_MAX_COLS) c = DEF_MAX_COLS;
            return c;
        endfunction

        function int eff_rows();
            int r;
            r = frame_rows;
            if (r == 0) r = 1;
            if (r > DEF_MAX_ROWS) r = DEF_MAX_ROWS;
            return r;
        endfunction

        // Levels are tested in rising priority, so a later equal level overrides.
        function class_t class_of(logic [PIXEL_W-1:0] v);
            class_t c;
            c = CLS_OTHER;
            if (v == lvl_low) c = CLS_LOW;
            if (v == lvl_mid) c = CLS_MID;
            if (v == lvl_high) c = CLS_HIGH;
            return c;
        endfunction

        function void clear_row();
            foreach (run_cls[i]) run_cls[i] = CLS_OTHER;
            foreach (run_mid[i]) run_mid[i] = '0;
            runs_seen = 0;
            row_hit   = 1'b0;
            row_mid   = '0;
            col_pos   = '0;
            run_val   = '0;
            run_len   = '0;
        endfunction

        function void close_run(int last_idx);
            class_t t;
            int     half;
            int     mid;
            t    = class_of(run_val);
            half = int'(run_len) / 2;
            mid  = (last_idx >= half) ? last_idx - half : 0;
            if (!row_hit && runs_seen >= 4 && run_cls[0] == CLS_LOW && run_cls[1] == CLS_HIGH &&
                run_cls[2] == CLS_MID && run_cls[3] == CLS_HIGH && t == CLS_LOW)
            begin
                row_hit = 1'b1;
                row_mid = run_mid[0];
            end
            run_cls[0] = run_cls[1];
            run_cls[1] = run_cls[2];
            run_cls[2] = run_cls[3];
            run_cls[3] = t;
            run_mid[0] = run_mid[1];
            run_mid[1] = OUT_W'(mid);
            if (runs_seen < 4) runs_seen++;
        endfunction

        function void set_register(logic [CFG_INDEX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                REG_ROW_WIDTH:  row_width  = data[ROW_WIDTH_W-1:0];
                REG_FRAME_ROWS: frame_rows = data[FRAME_ROWS_W-1:0];
                REG_LEVEL_LOW:  lvl_low    = data[PIXEL_W-1:0];
                REG_LEVEL_MID:  lvl_mid    = data[PIXEL_W-1:0];
                REG_LEVEL_HIGH: lvl_high   = data[PIXEL_W-1:0];
                default: ;
            endcase
        endfunction

        function void note_pixel(logic [PIXEL_W-1:0] px);
            int           cols;
            int           rows;
            int           drift;
            verdict_rec_t rec;
            cols = eff_cols();
            rows = eff_rows();
            if (col_pos == 0)
            begin
                run_val = px;
                run_len = 12'd1;
            end
            else if (px == run_val)
            begin
                run_len++;
            end
            else
            begin
                close_run(int'(col_pos) - 1);
                run_val = px;
                run_len = 12'd1;
            end
            if (int'(col_pos) + 1 < cols)
            begin
                col_pos++;
                return;
            end

            close_run(int'(col_pos));
            if (row_hit)
            begin
                hits++;
                if (!any_hit) first_mid = row_mid;
                last_mid = row_mid;
                any_hit  = 1'b1;
            end
            clear_row();
            row_pos++;
            if (int'(row_pos) < rows) return;

            if (int'(hits) * 10 < rows * 7)
            begin
                rec.verdict = VERD_NONE;
            end
            else
            begin
                drift = int'(last_mid) - int'(first_mid);
                if (drift * 10 < -cols)
                    rec.verdict = VERD_RIGHT;
                else if (drift * 10 > cols)
                    rec.verdict = VERD_LEFT;
                else
                    rec.verdict = VERD_STRAIGHT;
            end
            rec.rows_matched = hits;
            rec.first_center = first_mid;
            rec.last_center  = last_mid;
            pending_verdicts.push_back(rec);
            row_pos   = '0;
            hits      = '0;
            first_mid = '0;
            last_mid  = '0;
            any_hit   = 1'b0;
        endfunction

        task report(string what);
            errors++;
            $display("%0t mismatch: %s", $time, what);
        endtask

        task check_verdict(verdict_rec_t got);
            verdict_rec_t want;
            if (pending_verdicts.size() == 0)
            begin
                report($sformatf("verdict %0d rows %0d first %0d last %0d with no frame ended",
                                 got.verdict, got.rows_matched, got.first_center,
                                 got.last_center));
                return;
            end
            want = pending_verdicts.pop_front();
            checked++;
            verdict_tally[int'(want.verdict)]++;
            if (got.verdict !== want.verdict || got.rows_matched !== want.rows_matched ||
                got.first_center !== want.first_center || got.last_center !== want.last_center)
                report($sformatf("got/want verdict %0d/%0d rows %0d/%0d first %0d/%0d last %0d/%0d",
                                 got.verdict, want.verdict, got.rows_matched, want.rows_matched,
                                 got.first_center, want.first_center,
                                 got.last_center, want.last_center));
        endtask
    endclass

    logic clk = 1'b0;
    logic rst_n;

    tsr_pixel_if  pix_ch ();
    tsr_result_if res_ch ();
    tsr_cfg_if    cfg_ch ();

    track_shape_from_runs u_dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .pixels  (pix_ch),
        .results (res_ch),
        .cfg     (cfg_ch)
    );

    verdict_board sb;
    bit           tx_gaps;
    bit           rx_gaps;
    bit           hold_req;
    bit           count_items;
    int           random_items;
    int           pixels_sent;
    int           settings_used;
    int           quiet;

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Receiver: random stall bursts, plus one long hold when the stimulus asks for it.
    initial
    begin
        int stall_left;
        res_ch.ready = 1'b0;
        stall_left   = 0;
        forever
        begin
            @(negedge clk);
            if (hold_req)
            begin
                hold_req   = 1'b0;
                stall_left = HOLD_CYCLES;
            end
            else if (stall_left == 0 && rx_gaps && $urandom_range(0, 7) == 0)
            begin
                stall_left = $urandom_range(1, 16);
            end
            if (stall_left > 0)
            begin
                res_ch.ready <= 1'b0;
                stall_left--;
            end
            else
            begin
                res_ch.ready <= 1'b1;
            end
        end
    end

    always @(posedge clk)
    begin
        verdict_rec_t seen;
        if (rst_n && res_ch.valid && res_ch.ready)
        begin
            seen.verdict      = res_ch.verdict;
            seen.rows_matched = res_ch.rows_matched;
            seen.first_center = res_ch.first_center;
            seen.last_center  = res_ch.last_center;
            sb.check_verdict(seen);
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (pix_ch.valid && pix_ch.ready) || (res_ch.valid && res_ch.ready) ||
            (cfg_ch.valid && cfg_ch.ready))
        begin
            quiet = 0;
        end
        else
        begin
            quiet++;
            if (quiet >= QUIET_LIMIT)
            begin
                $display("watchdog: no request moved for %0d cycles, %0d verdicts outstanding",
                         quiet, sb.pending_verdicts.size());
                $display("tb: failure");
                $finish;
            end
        end
    end

    task automatic put_pixel(input logic [PIXEL_W-1:0] px);
        int gap;
        @(negedge clk);
        if (tx_gaps && $urandom_range(0, 7) == 0)
        begin
            gap = $urandom_range(1, 16);
            pix_ch.valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        pix_ch.valid <= 1'b1;
        pix_ch.pixel <= px;
        do @(posedge clk); while (!pix_ch.ready);
        sb.note_pixel(px);
        pixels_sent++;
        if (count_items) random_items++;
    endtask

    task automatic write_reg(input logic [CFG_INDEX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        @(negedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.index <= idx;
        cfg_ch.wdata <= data;
        do @(posedge clk); while (!cfg_ch.ready);
        sb.set_register(idx, data);
    endtask

    // Unused upper data bits carry random values to show they are dropped.
    task automatic configure(input int w, input int h, input int lo, input int mid,
                             input int hi, input bit stray);
        write_reg(REG_ROW_WIDTH, CFG_DATA_W'(w));
        write_reg(REG_FRAME_ROWS, {1'($urandom), FRAME_ROWS_W'(h)});
        write_reg(REG_LEVEL_LOW, {4'($urandom), PIXEL_W'(lo)});
        write_reg(REG_LEVEL_MID, {4'($urandom), PIXEL_W'(mid)});
        write_reg(REG_LEVEL_HIGH, {4'($urandom), PIXEL_W'(hi)});
        if (stray)
            for (int i = int'(REG_LEVEL_HIGH) + 1; i < (1 << CFG_INDEX_W); i++)
                write_reg(CFG_INDEX_W'(i), CFG_DATA_W'($urandom));
        @(negedge clk);
        cfg_ch.valid <= 1'b0;
        settings_used++;
    endtask

    // Waits until every predicted verdict is in, then lets the pipeline drain.
    task automatic settle();
        @(negedge clk);
        pix_ch.valid <= 1'b0;
        while (sb.pending_verdicts.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    function automatic logic [PIXEL_W-1:0] any_level();
        case ($urandom_range(0, 3))
            0: return sb.lvl_low;
            1: return sb.lvl_mid;
            2: return sb.lvl_high;
            default: return PIXEL_W'($urandom);
        endcase
    endfunction

    // A clean row places the low, high, mid, high, low sequence at a random offset with
    // random run lengths; the rest of the row, and all of a noisy row, is random.
    task automatic send_row(input bit noisy);
        logic [PIXEL_W-1:0] row_px [$];
        logic [PIXEL_W-1:0] pat [5];
        int                 lens [5];
        int                 w;
        int                 extra;
        int                 lead;
        w   = sb.eff_cols();
        pat = '{sb.lvl_low, sb.lvl_high, sb.lvl_mid, sb.lvl_high, sb.lvl_low};
        if (!noisy && w >= 5)
        begin
            foreach (lens[k]) lens[k] = 1;
            extra = $urandom_range(0, (w - 5 > 12) ? 12 : w - 5);
            repeat (extra) lens[$urandom_range(0, 4)]++;
            lead = $urandom_range(0, w - 5 - extra);
            repeat (lead) row_px.push_back(any_level());
            foreach (pat[k]) repeat (lens[k]) row_px.push_back(pat[k]);
        end
        while (row_px.size() < w) row_px.push_back(any_level());
        foreach (row_px[i]) put_pixel(row_px[i]);
    endtask

    task automatic send_frame();
        repeat (sb.eff_rows()) send_row($urandom_range(0, 4) == 0);
    endtask

    initial
    begin
        int dir_px [$];
        int phase;
        int w;
        int h;
        int lo;
        int mid;
        int hi;
        int left;

        sb            = new();
        rst_n         = 1'b0;
        pix_ch.valid  = 1'b0;
        pix_ch.pixel  = '0;
        cfg_ch.valid  = 1'b0;
        cfg_ch.index  = '0;
        cfg_ch.wdata  = '0;
        tx_gaps       = 1'b0;
        rx_gaps       = 1'b0;
        hold_req      = 1'b0;
        count_items   = 1'b0;
        random_items  = 0;
        pixels_sent   = 0;
        settings_used = 0;
        quiet         = 0;
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Two matched rows out of three fall short of the match ratio: no estimate,
        // yet the counts and centres are still reported.
        configure(5, 3, 0, 128, 255, 1'b1);
        dir_px = '{0, 255, 128, 255, 0, 0, 255, 128, 255, 0, 255, 0, 255, 128, 255};
        foreach (dir_px[i]) put_pixel(PIXEL_W'(dir_px[i]));
        // A single matched row gives zero distance, hence straight.
        settle();
        configure(5, 1, 0, 128, 255, 1'b0);
        dir_px = '{0, 255, 128, 255, 0};
        foreach (dir_px[i]) put_pixel(PIXEL_W'(dir_px[i]));
        // Low and mid share a value, so mid wins and the sequence must not match.
        settle();
        configure(5, 1, 7, 7, 9, 1'b0);
        dir_px = '{7, 9, 7, 9, 7};
        foreach (dir_px[i]) put_pixel(PIXEL_W'(dir_px[i]));
        // Zero width and zero rows act as one: every pixel closes a frame with no match.
        settle();
        configure(0, 0, 0, 128, 255, 1'b0);
        put_pixel(8'd0);
        put_pixel(8'd255);

        phase = 0;
        while (random_items < ITEM_TARGET)
        begin
            phase++;
            settle();
            if (random_items > ITEM_TARGET * 4 / 5)
            begin
                tx_gaps = 1'b0;
                rx_gaps = 1'b0;
            end
            else
            begin
                tx_gaps = $urandom_range(0, 2) != 0;
                rx_gaps = $urandom_range(0, 2) != 0;
            end
            lo  = $urandom_range(0, 255);
            mid = $urandom_range(0, 255);
            hi  = $urandom_range(0, 255);
            case ($urandom_range(0, 9))
                0: mid = lo;
                1: hi = mid;
                2:
                begin
                    lo = 0;
                    hi = 255;
                end
                default: ;
            endcase
            count_items = 1'b0;
            case (phase)
                3:  configure(2048, 0, lo, mid, hi, 1'b0);
                6:  configure(1, 1024, lo, mid, hi, 1'b0);
                12: configure(4095, 1, lo, mid, hi, 1'b1);
                15: configure(0, 2047, lo, mid, hi, 1'b0);
                9:
                begin
                    // Tiny frames with the output held off long enough to fill the
                    // request queue and push back on the pixel input.
                    configure(1, 1, lo, mid, hi, 1'b0);
                    count_items = 1'b1;
                    tx_gaps     = 1'b0;
                    hold_req    = 1'b1;
                    repeat (40) put_pixel(any_level());
                end
                default:
                begin
                    w = $urandom_range(5, 14);
                    h = $urandom_range(1, 4);
                    if ($urandom_range(0, 11) == 0) w = $urandom_range(0, 4);
                    if ($urandom_range(0, 11) == 0) h = 0;
                    configure(w, h, lo, mid, hi, $urandom_range(0, 7) == 0);
                    count_items = 1'b1;
                    repeat ($urandom_range(1, 3)) send_frame();
                    // Leave a frame unfinished so the next settings land mid frame.
                    left = sb.eff_cols() * sb.eff_rows() - 1;
                    if (left > 0 && $urandom_range(0, 3) == 0)
                        repeat ($urandom_range(1, left)) put_pixel(any_level());
                end
            endcase
            // Extreme geometries get only part of a frame, so the small settings that
            // follow find the counters already past their new limits.
            if (phase == 3 || phase == 12 || phase == 6 || phase == 15)
            begin
                count_items = 1'b1;
                repeat ($urandom_range(20, 60)) put_pixel(any_level());
            end
        end

        settle();
        $display("summary: %0d pixels over %0d register settings, %0d frame verdicts checked",
                 pixels_sent, settings_used, sb.checked);
        $display("summary: none %0d, right %0d, left %0d, straight %0d; one %0d cycle output hold",
                 sb.verdict_tally[VERD_NONE], sb.verdict_tally[VERD_RIGHT],
                 sb.verdict_tally[VERD_LEFT], sb.verdict_tally[VERD_STRAIGHT], HOLD_CYCLES);
        if (sb.errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end
endmodule
